// ===== hdl/mpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ENT_W   = 5;
  localparam int unsigned MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  // spare code: no operation, status only
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  localparam logic signed [VAL_W-1:0] EMPTY_SMALLEST = -32'sd1;
  localparam logic signed [VAL_W-1:0] EMPTY_LARGEST  = 32'sd0;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } cell_ctrl_t;

  // One result transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] smallest;
    logic signed [VAL_W-1:0] largest;
    logic [ENT_W-1:0]        entries;
    logic                    empty_res;
    logic                    overflow;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/mpq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain. On push it keeps, takes the new value, or
// takes its left neighbor; on pop it takes its right neighbor; clear empties it.
// ----------------------------------------------------------------------------
module mpq_cell import mpq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic signed [VAL_W-1:0] prev_val_i,
  input  wire logic                    prev_valid_i,
  input  wire logic                    prev_gt_i,
  input  wire logic signed [VAL_W-1:0] next_val_i,
  input  wire logic                    next_valid_i,
  output logic signed [VAL_W-1:0]      val_o,
  output logic                         valid_o,
  output logic                         gt_o
);

  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    valid_q, valid_d;

  // An empty cell counts as holding +infinity
  assign gt_o = !valid_q || (val_q > value_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.push) begin
      if (gt_o) begin
        valid_d = valid_q | prev_valid_i;
        val_d   = prev_gt_i ? prev_val_i : value_i;
      end
    end else if (ctrl_i.pop) begin
      val_d   = next_val_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== hdl/mpq_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_out_buf
// Two-entry result buffer; decouples the output stall from the input side.
// ----------------------------------------------------------------------------
module mpq_out_buf import mpq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  res_t       ent0_q, ent1_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign res_o       = ent0_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i && cnt_q == 2'd1) begin
        ent0_q <= res_i;
      end else begin
        ent0_q <= ent1_q;
      end
      if (push_i && cnt_q == 2'd2) begin
        ent1_q <= res_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= res_i;
      end else begin
        ent1_q <= res_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/min_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_priority_queue
// Bounded sorted priority queue built as a shift-register chain of cells.
// ----------------------------------------------------------------------------
// Each input transaction (push, pop smallest, clear) is applied to the whole
// chain of CAPACITY cells at once: every cell compares its entry with the
// broadcast value and keeps, takes it, or takes a neighbor, so the chain stays
// sorted with the smallest in cell 0. One transaction is taken per cycle unless
// stalled; results are registered in a two-entry output buffer, and input
// stall rises only when both buffer entries wait on the output. A push into
// a full queue is dropped and flagged with overflow; a pop of an empty queue
// does nothing. smallest reads -1 and largest reads 0 when the queue is empty.
module min_priority_queue import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [MODE_W-1:0]       mode_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [VAL_W-1:0]      smallest_o,
  output logic signed [VAL_W-1:0]      largest_o,
  output logic [ENT_W-1:0]             entries_o,
  output logic                         empty_res_o,
  output logic                         overflow_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                    accept;
  logic                    buf_full;
  logic                    is_push, is_pop, is_clear;
  logic                    full, none;
  cell_ctrl_t              ctrl;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [VAL_W-1:0] largest_q, largest_d;
  logic signed [VAL_W-1:0] small_d;
  res_t                    res, res_out;

  logic signed [VAL_W-1:0] cell_val   [CAPACITY];
  logic [CAPACITY-1:0]     cell_valid;
  logic [CAPACITY-1:0]     cell_gt;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  assign is_push  = accept && (mode_i == MODE_PUSH);
  assign is_pop   = accept && (mode_i == MODE_POP);
  assign is_clear = accept && (mode_i == MODE_CLEAR);

  assign full = (count_q == CNT_W'(CAPACITY));
  assign none = (count_q == '0);

  assign ctrl.push  = is_push && !full;
  assign ctrl.pop   = is_pop && !none;
  assign ctrl.clear = is_clear;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_val, next_val;
    logic                    prev_valid, prev_gt, next_valid;

    if (i == 0) begin : g_head
      assign prev_val   = '0;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_val   = cell_val[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val   = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_val   = cell_val[i+1];
      assign next_valid = cell_valid[i+1];
    end

    mpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .value_i     (value_i),
      .prev_val_i  (prev_val),
      .prev_valid_i(prev_valid),
      .prev_gt_i   (prev_gt),
      .next_val_i  (next_val),
      .next_valid_i(next_valid),
      .val_o       (cell_val[i]),
      .valid_o     (cell_valid[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Occupancy, running maximum and the post-operation minimum
  always_comb begin
    count_d   = count_q;
    largest_d = largest_q;
    small_d   = cell_val[0];
    if (ctrl.clear) begin
      count_d = '0;
    end else if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
      if (none || value_i > largest_q) begin
        largest_d = value_i;
      end
      if (none || value_i < cell_val[0]) begin
        small_d = value_i;
      end
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
      small_d = cell_val[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    largest_q <= largest_d;
  end

  always_comb begin
    res.empty_res = (count_d == '0);
    res.smallest  = res.empty_res ? EMPTY_SMALLEST : small_d;
    res.largest   = res.empty_res ? EMPTY_LARGEST : largest_d;
    res.entries   = ENT_W'(count_d);
    res.overflow  = is_push && full;
  end

  mpq_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign smallest_o  = res_out.smallest;
  assign largest_o   = res_out.largest;
  assign entries_o   = res_out.entries;
  assign empty_res_o = res_out.empty_res;
  assign overflow_o  = res_out.overflow;

  // The number of occupied cells equals the count
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("cell valid bits disagree with occupancy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // Head of the chain stays sorted
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_val[0] <= cell_val[1]))
    else $error("chain head out of order");

  // A refused push leaves the occupancy untouched
  a_refused_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_push && full) |=> (count_q == CNT_W'(CAPACITY)))
    else $error("refused push changed occupancy");

endmodule
`default_nettype wire
